// File: rtl/ptrr_pkg.sv
// Shared types, command codes and constants for the process table scheduler.
package ptrr_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int PID_W     = 5;
  localparam int MOD_W     = 32;
  localparam int CMD_W     = 3;
  localparam int PID_BASE  = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE_PID = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE_MOD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_MOD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             proc_kind;
    logic [MOD_W-1:0] module_id;
    logic [PID_W-1:0] proc_id;
  } req_t;

  typedef struct packed {
    logic             success;
    logic [PID_W-1:0] result_pid;
    logic             result_kind;
    logic [MOD_W-1:0] result_module_id;
  } res_t;

endpackage

// File: rtl/ptrr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ptrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/process_table_round_robin_core.sv
// Process slot table: allocate, free, find by module id, round-robin pick.
// Steps: allocate, failures and unknown commands answer from the decode
// state; free by pid and next ready go through decode and a read state;
// free/find by module id scan the module id RAM, one read per cycle, over at
// most SLOTS entries. busy drops with the last step, so a new item
// may be taken in the cycle its predecessor's result shows. Reset clears all
// slots and the round-robin pointer at once; the receiver cannot stall.
module process_table_round_robin_core #(
  parameter int SLOTS = ptrr_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ptrr_pkg::req_t request,
  output logic           done,
  output ptrr_pkg::res_t result
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int OFF_W = ((IDX_W + 1 > ptrr_pkg::PID_W) ? IDX_W + 1 : ptrr_pkg::PID_W) + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_READ   = 4'b0100,
    ST_SCAN   = 4'b1000
  } state_t;

  state_t                       state, state_next;
  ptrr_pkg::req_t               req;
  ptrr_pkg::res_t               result_next;
  logic                         done_next;
  logic [SLOTS-1:0]             in_use, in_use_next;
  logic [SLOTS-1:0]             kind, kind_next;
  logic [IDX_W-1:0]             last_picked, last_picked_next;
  logic [IDX_W-1:0]             scan_addr, scan_addr_next;
  logic [IDX_W-1:0]             sel_slot, sel_slot_next;

  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [ptrr_pkg::MOD_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]             ram_raddr;
  logic [ptrr_pkg::MOD_W-1:0]   ram_rdata;

  logic [IDX_W:0]               free_pick, rr_hi_pick, rr_all_pick;
  logic [SLOTS-1:0]             rr_cand, rr_hi_mask;
  logic [IDX_W-1:0]             rr_start;
  logic                         rr_found;
  logic [IDX_W-1:0]             rr_slot;
  logic [OFF_W-1:0]             pid_off;
  logic                         pid_ok;
  logic [IDX_W-1:0]             pid_slot;
  logic                         scan_hit;

  // {found, index} of the lowest set bit
  function automatic logic [IDX_W:0] lowest(input logic [SLOTS-1:0] v);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, IDX_W'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [ptrr_pkg::PID_W-1:0] pid_of(input logic [IDX_W-1:0] slot);
    logic [OFF_W-1:0] sum;
    sum = OFF_W'(slot) + OFF_W'(ptrr_pkg::PID_BASE);
    return sum[ptrr_pkg::PID_W-1:0];
  endfunction

  ptrr_ram #(
    .WIDTH (ptrr_pkg::MOD_W),
    .DEPTH (SLOTS)
  ) u_mod_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != ST_IDLE);

  // Lowest free slot for allocate
  assign free_pick = lowest(~in_use);

  // Round robin over in-use user slots, starting after the last pick
  assign rr_cand  = in_use & ~kind;
  assign rr_start = (last_picked == LAST) ? '0 : last_picked + 1'b1;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      rr_hi_mask[i] = (IDX_W'(i) >= rr_start);
    end
  end

  assign rr_hi_pick  = lowest(rr_cand & rr_hi_mask);
  assign rr_all_pick = lowest(rr_cand);
  assign rr_found    = rr_all_pick[IDX_W];
  assign rr_slot     = rr_hi_pick[IDX_W] ? rr_hi_pick[IDX_W-1:0] : rr_all_pick[IDX_W-1:0];

  assign pid_off  = OFF_W'(req.proc_id) - OFF_W'(ptrr_pkg::PID_BASE);
  assign pid_ok   = (req.proc_id >= ptrr_pkg::PID_W'(ptrr_pkg::PID_BASE)) &&
                    (pid_off < OFF_W'(SLOTS));
  assign pid_slot = pid_off[IDX_W-1:0];

  assign scan_hit = in_use[scan_addr] && (ram_rdata == req.module_id);

  always_comb begin
    state_next       = state;
    in_use_next      = in_use;
    kind_next        = kind;
    last_picked_next = last_picked;
    scan_addr_next   = scan_addr;
    sel_slot_next    = sel_slot;
    done_next        = 1'b0;
    result_next      = result;
    ram_we           = 1'b0;
    ram_waddr        = free_pick[IDX_W-1:0];
    ram_wdata        = req.module_id;
    ram_raddr        = scan_addr;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DECODE;
        end
      end

      ST_DECODE: begin
        // failures and unknown commands answer all zero right away
        state_next  = ST_IDLE;
        done_next   = 1'b1;
        result_next = '0;
        case (req.command) inside
          ptrr_pkg::CMD_ALLOC: begin
            if (free_pick[IDX_W]) begin
              in_use_next[free_pick[IDX_W-1:0]] = 1'b1;
              kind_next[free_pick[IDX_W-1:0]]   = req.proc_kind;
              ram_we                            = 1'b1;
              result_next.success               = 1'b1;
              result_next.result_pid            = pid_of(free_pick[IDX_W-1:0]);
              result_next.result_kind           = req.proc_kind;
              result_next.result_module_id      = req.module_id;
            end
          end
          ptrr_pkg::CMD_FREE_PID: begin
            if (pid_ok && in_use[pid_slot]) begin
              sel_slot_next = pid_slot;
              ram_raddr     = pid_slot;
              state_next    = ST_READ;
              done_next     = 1'b0;
            end
          end
          ptrr_pkg::CMD_NEXT: begin
            if (rr_found) begin
              last_picked_next = rr_slot;
              sel_slot_next    = rr_slot;
              ram_raddr        = rr_slot;
              state_next       = ST_READ;
              done_next        = 1'b0;
            end
          end
          ptrr_pkg::CMD_FREE_MOD, ptrr_pkg::CMD_FIND_MOD: begin
            scan_addr_next = '0;
            ram_raddr      = '0;
            state_next     = ST_SCAN;
            done_next      = 1'b0;
          end
          default: begin
          end
        endcase
      end

      ST_READ: begin
        state_next                   = ST_IDLE;
        done_next                    = 1'b1;
        result_next.success          = 1'b1;
        result_next.result_pid       = pid_of(sel_slot);
        result_next.result_kind      = kind[sel_slot];
        result_next.result_module_id = ram_rdata;
        if (req.command == ptrr_pkg::CMD_FREE_PID) begin
          in_use_next[sel_slot] = 1'b0;
          kind_next[sel_slot]   = 1'b0;
        end
      end

      ST_SCAN: begin
        if (scan_hit) begin
          state_next                   = ST_IDLE;
          done_next                    = 1'b1;
          result_next.success          = 1'b1;
          result_next.result_pid       = pid_of(scan_addr);
          result_next.result_kind      = kind[scan_addr];
          result_next.result_module_id = ram_rdata;
          if (req.command == ptrr_pkg::CMD_FREE_MOD) begin
            in_use_next[scan_addr] = 1'b0;
            kind_next[scan_addr]   = 1'b0;
          end
        end else if (scan_addr == LAST) begin
          state_next  = ST_IDLE;
          done_next   = 1'b1;
          result_next = '0;
        end else begin
          // advance one slot per cycle through the RAM
          scan_addr_next = scan_addr + 1'b1;
          ram_raddr      = scan_addr + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      in_use      <= '0;
      kind        <= '0;
      last_picked <= '0;
    end else begin
      state       <= state_next;
      done        <= done_next;
      in_use      <= in_use_next;
      kind        <= kind_next;
      last_picked <= last_picked_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req <= request;
    end
    result    <= result_next;
    scan_addr <= scan_addr_next;
    sel_slot  <= sel_slot_next;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != ST_IDLE))
    else $error("result strobe without a command in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.success) |->
      (result.result_pid == '0) && (result.result_kind == 1'b0) &&
      (result.result_module_id == '0))
    else $error("failed result carries nonzero fields");

  a_last_range: assert property (@(posedge clk) disable iff (rst)
    last_picked <= LAST)
    else $error("round-robin pointer out of range");

  a_pick_is_user: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && req.command == ptrr_pkg::CMD_NEXT) |->
      (in_use[sel_slot] && !kind[sel_slot]))
    else $error("next ready picked a slot that is not an in-use user slot");

endmodule
